[rtl/core/hlfr_pkg.sv]
`default_nettype none
package hlfr_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int BYTE_W = 8;
  localparam int TIME_W = 32;
  localparam int WORD_W = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int S_TDATA_W = BYTE_W + TIME_W;
  localparam int HDR_BYTES = 4;
  localparam int LEN_OFFSET = 4;
  // a frame is judged from this stored count on (seventh byte arriving)
  localparam int CHECK_FROM = 6;

  localparam logic [WORD_W-1:0] HEADER_WORD_RESET = 32'h1000_00C5;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd500;

  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_WORD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } emit_state_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] len;
  } frame_done_t;

endpackage
`default_nettype wire

[rtl/core/hlfr_ram.sv]
`default_nettype none
module hlfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/hlfr_collect.sv]
`default_nettype none
module hlfr_collect (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  input  wire logic [hlfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [hlfr_pkg::WORD_W-1:0]       cfg_data,
  input  wire logic                              in_take,
  input  wire logic [hlfr_pkg::BYTE_W-1:0]       byte_value,
  input  wire logic [hlfr_pkg::TIME_W-1:0]       arrival_time,
  output logic                                   wr_en,
  output logic      [hlfr_pkg::ADDR_W-1:0]       wr_addr,
  output logic      [hlfr_pkg::BYTE_W-1:0]       wr_data,
  output hlfr_pkg::frame_done_t                  done
);

  localparam int CNT_W = hlfr_pkg::CNT_W;
  localparam int BYTE_W = hlfr_pkg::BYTE_W;

  logic [hlfr_pkg::WORD_W-1:0] header_word;
  logic [hlfr_pkg::TIME_W-1:0] timeout_ticks;
  logic [CNT_W-1:0]            byte_count;
  logic [CNT_W-1:0]            byte_count_next;
  logic [hlfr_pkg::TIME_W-1:0] last_arrival;
  // copies of the header and length entries of the frame store
  logic [BYTE_W-1:0]           hdr [hlfr_pkg::HDR_BYTES];
  logic [BYTE_W-1:0]           len_byte;

  logic [hlfr_pkg::TIME_W-1:0] gap;
  logic [CNT_W-1:0]            base;
  logic [CNT_W-1:0]            base_inc;
  logic                        judge;
  logic                        hdr_ok;
  logic                        complete;
  logic [CNT_W-1:0]            cnt_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_word   <= hlfr_pkg::HEADER_WORD_RESET;
      timeout_ticks <= hlfr_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        hlfr_pkg::CFG_HEADER_WORD:   header_word   <= cfg_data;
        hlfr_pkg::CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    gap      = arrival_time - last_arrival;
    base     = ((byte_count != '0) && (gap > timeout_ticks)) ? '0 : byte_count;
    base_inc = base + CNT_W'(1);
    judge    = base >= CNT_W'(hlfr_pkg::CHECK_FROM);
    hdr_ok   = 1'b1;
    for (int k = 0; k < hlfr_pkg::HDR_BYTES; k++) begin
      if (hdr[k] != header_word[hlfr_pkg::WORD_W-1-BYTE_W*k -: BYTE_W]) begin
        hdr_ok = 1'b0;
      end
    end
    complete = judge && hdr_ok && (len_byte == BYTE_W'(base_inc));
    if (judge && (!hdr_ok || complete)) begin
      cnt_step = '0;
    end else begin
      cnt_step = base_inc;
    end
    byte_count_next = (cnt_step >= CNT_W'(hlfr_pkg::BUFFER_DEPTH)) ? '0 : cnt_step;
  end

  assign wr_en      = in_take;
  assign wr_addr    = base[hlfr_pkg::ADDR_W-1:0];
  assign wr_data    = byte_value;
  assign done.valid = in_take && complete;
  assign done.len   = base_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      last_arrival <= '0;
    end else if (in_take) begin
      byte_count   <= byte_count_next;
      last_arrival <= arrival_time;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int k = 0; k < hlfr_pkg::HDR_BYTES; k++) begin
        if (base == CNT_W'(k)) begin
          hdr[k] <= byte_value;
        end
      end
      if (base == CNT_W'(hlfr_pkg::LEN_OFFSET)) begin
        len_byte <= byte_value;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/hlfr_emit.sv]
`default_nettype none
module hlfr_emit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire hlfr_pkg::frame_done_t       done,
  input  wire logic                        m_tready,
  output logic                             m_tvalid,
  output logic                             m_tlast,
  output logic                             busy,
  output logic                             rd_en,
  output logic      [hlfr_pkg::ADDR_W-1:0] rd_addr
);

  localparam int CNT_W = hlfr_pkg::CNT_W;

  hlfr_pkg::emit_state_t state;
  hlfr_pkg::emit_state_t state_next;
  logic [CNT_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      frame_len;
  logic                  slot_free;
  logic                  at_last;

  assign slot_free = !m_tvalid || m_tready;
  assign at_last   = (rd_ptr + CNT_W'(1)) == frame_len;
  assign rd_addr   = rd_ptr[hlfr_pkg::ADDR_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      hlfr_pkg::ST_IDLE: begin
        if (done.valid) begin
          state_next = hlfr_pkg::ST_EMIT;
        end
      end
      hlfr_pkg::ST_EMIT: begin
        if (slot_free && at_last) begin
          state_next = hlfr_pkg::ST_IDLE;
        end
      end
      default: state_next = hlfr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      hlfr_pkg::ST_EMIT: begin
        busy  = 1'b1;
        rd_en = slot_free;
      end
      default: begin
        busy  = 1'b0;
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hlfr_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
      rd_ptr   <= '0;
    end else begin
      state <= state_next;
      // the RAM read register is the output stage; it only moves on rd_en
      if (rd_en) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (done.valid) begin
        rd_ptr <= '0;
      end else if (rd_en) begin
        rd_ptr <= rd_ptr + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done.valid) begin
      frame_len <= done.len;
    end
    if (rd_en) begin
      m_tlast <= at_last;
    end
  end

endmodule
`default_nettype wire

[rtl/core/header_length_frame_receiver.sv]
`default_nettype none
// Frame receiver: bytes arrive on s_* with a timestamp and are written into a
// 64-entry frame RAM, one request per cycle while collecting. A gap above
// timeout_ticks drops a partial frame; from the seventh byte on, bytes 0..3
// must equal header_word (byte 0 in the top bits) or the frame is dropped; a
// frame that fills the buffer without completing is dropped. When the stored
// count equals the length byte at offset 4, the frame of n bytes is read back
// from the RAM's single read port onto m_*, one byte per cycle if m_tready
// allows, m_tlast on the final byte. While a frame is read out s_tready is
// low, so no new byte is taken until the final byte is read from the RAM.
// Registers may be written through cfg_* at any time the block is idle;
// cfg_ready is always high. No clearing pass after reset.
module header_length_frame_receiver (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [hlfr_pkg::S_TDATA_W-1:0]    s_tdata,  // byte_value[7:0], arrival_time[39:8]
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [hlfr_pkg::BYTE_W-1:0]       m_tdata,  // frame_byte[7:0]
  output logic                                   m_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hlfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [hlfr_pkg::WORD_W-1:0]       cfg_data
);

  logic                          busy;
  logic                          in_take;
  logic                          wr_en;
  logic [hlfr_pkg::ADDR_W-1:0]   wr_addr;
  logic [hlfr_pkg::BYTE_W-1:0]   wr_data;
  logic                          rd_en;
  logic [hlfr_pkg::ADDR_W-1:0]   rd_addr;
  hlfr_pkg::frame_done_t         done;

  assign s_tready  = !busy;
  assign in_take   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  hlfr_collect u_collect (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_take      (in_take),
    .byte_value   (s_tdata[hlfr_pkg::BYTE_W-1:0]),
    .arrival_time (s_tdata[hlfr_pkg::S_TDATA_W-1:hlfr_pkg::BYTE_W]),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .done         (done)
  );

  hlfr_ram #(
    .WIDTH (hlfr_pkg::BYTE_W),
    .DEPTH (hlfr_pkg::BUFFER_DEPTH)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (m_tdata)
  );

  hlfr_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .done     (done),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tlast  (m_tlast),
    .busy     (busy),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr)
  );

endmodule
`default_nettype wire
